@@ rtl/core/two_level_page_table_top_macros.svh @@
// assertion macros used by the page table controller
`ifndef TWO_LEVEL_PAGE_TABLE_TOP_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TLPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TLPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tlpt_pkg.sv @@
// shared constants, status codes and control structs of the page table
`timescale 1ns / 1ps

package tlpt_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 8;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned DIR_ENTRIES     = 1024;
  localparam int unsigned TBL_ENTRIES     = 1024;
  localparam int unsigned OFF_W           = 12;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned FLAGS_W         = 12;
  localparam int unsigned DIR_LSB         = 22;
  localparam int unsigned PAGE_LSB        = 12;

  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 32;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_MAP       = 1'b1;

  localparam logic [STATUS_W-1:0] ST_TRANSLATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MAPPED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_TABLE   = 3'd4;

  typedef struct packed {
    logic clear;
    logic load;
    logic alloc;
    logic page_rd;
    logic fin_dir;
    logic fin_page;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic op;
    logic dir_present;
    logic pool_full;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/tlpt_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tlpt_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tlpt_datapath.sv @@
// directory and page memories, slot allocator, clear sweep and result register
`timescale 1ns / 1ps

module tlpt_datapath #(
  parameter int unsigned TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_op_i,
  input  logic [tlpt_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  tlpt_pkg::dp_cmd_t                cmd_i,
  output tlpt_pkg::dp_status_t             sts_o,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [tlpt_pkg::STATUS_W-1:0]    m_status_o,
  output logic [tlpt_pkg::M_TDATA_W-1:0]   m_phys_o
);

  import tlpt_pkg::*;

  localparam int unsigned SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned PAGE_DEPTH = TABLE_SLOTS * TBL_ENTRIES;
  localparam int unsigned PAGE_AW    = $clog2(PAGE_DEPTH);
  localparam int unsigned DIR_W      = SLOT_W + 1;
  localparam int unsigned FRAME_W    = ADDR_W - OFF_W;

  // input transaction fields, vaddr at the bottom of tdata
  logic [ADDR_W-1:0]  in_vaddr;
  logic [ADDR_W-1:0]  in_paddr;
  logic [FLAGS_W-1:0] in_flags;

  assign in_vaddr = s_tdata_i[ADDR_W-1:0];
  assign in_paddr = s_tdata_i[2*ADDR_W-1:ADDR_W];
  assign in_flags = s_tdata_i[2*ADDR_W+FLAGS_W-1:2*ADDR_W];

  logic               op_q;
  logic [ADDR_W-1:0]  vaddr_q;
  logic [FRAME_W-1:0] frame_q;
  logic [FLAGS_W-1:0] flags_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= s_op_i;
      vaddr_q <= in_vaddr;
      frame_q <= in_paddr[ADDR_W-1:OFF_W];
      flags_q <= in_flags;
    end
  end

  // clear sweep and table allocator
  logic [PAGE_AW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]   next_q, next_d;
  logic               clear_done;
  logic               pool_full;
  logic [SLOT_W-1:0]  next_slot;

  assign clear_done = (clr_q == PAGE_AW'(PAGE_DEPTH - 1));
  assign pool_full  = (next_q == CNT_W'(TABLE_SLOTS));
  assign next_slot  = next_q[SLOT_W-1:0];
  assign clr_d      = cmd_i.clear ? clr_q + PAGE_AW'(1) : clr_q;
  assign next_d     = cmd_i.alloc ? next_q + CNT_W'(1) : next_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      next_q <= '0;
    end else begin
      clr_q  <= clr_d;
      next_q <= next_d;
    end
  end

  // directory memory: present bit on top of the table slot
  logic              dir_we;
  logic [IDX_W-1:0]  dir_waddr;
  logic [DIR_W-1:0]  dir_wdata;
  logic [DIR_W-1:0]  dir_rdata;
  logic              dir_present;
  logic [SLOT_W-1:0] dir_slot;

  assign dir_we    = cmd_i.clear | cmd_i.alloc;
  assign dir_waddr = cmd_i.clear ? clr_q[IDX_W-1:0] : vaddr_q[DIR_LSB+IDX_W-1:DIR_LSB];
  assign dir_wdata = cmd_i.clear ? '0 : {1'b1, next_slot};

  tlpt_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_ENTRIES),
    .ADDR_W(IDX_W)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .we_i   (dir_we),
    .waddr_i(dir_waddr),
    .wdata_i(dir_wdata),
    .re_i   (cmd_i.load),
    .raddr_i(in_vaddr[DIR_LSB+IDX_W-1:DIR_LSB]),
    .rdata_o(dir_rdata)
  );

  assign dir_present = dir_rdata[DIR_W-1];
  assign dir_slot    = dir_rdata[SLOT_W-1:0];

  // page entry address, held for the write back
  logic [SLOT_W-1:0]       slot_sel;
  logic [SLOT_W+IDX_W-1:0] page_addr_full;
  logic [PAGE_AW-1:0]      page_raddr;
  logic [PAGE_AW-1:0]      page_addr_q;

  assign slot_sel       = dir_present ? dir_slot : next_slot;
  assign page_addr_full = {slot_sel, vaddr_q[PAGE_LSB+IDX_W-1:PAGE_LSB]};
  assign page_raddr     = page_addr_full[PAGE_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.page_rd) begin
      page_addr_q <= page_raddr;
    end
  end

  logic               page_we;
  logic [PAGE_AW-1:0] page_waddr;
  logic [ADDR_W-1:0]  page_wdata;
  logic [ADDR_W-1:0]  page_rdata;
  logic               page_present;

  assign page_present = page_rdata[0];
  assign page_we      = cmd_i.clear | (cmd_i.fin_page & (op_q == OP_MAP) & ~page_present);
  assign page_waddr   = cmd_i.clear ? clr_q : page_addr_q;
  // present bit forced on whatever flags bit 0 holds
  assign page_wdata   = cmd_i.clear ? '0 : {frame_q, flags_q[FLAGS_W-1:1], 1'b1};

  tlpt_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (PAGE_DEPTH),
    .ADDR_W(PAGE_AW)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (page_we),
    .waddr_i(page_waddr),
    .wdata_i(page_wdata),
    .re_i   (cmd_i.page_rd),
    .raddr_i(page_raddr),
    .rdata_o(page_rdata)
  );

  // result selection
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_phys;

  always_comb begin
    res_status = ST_NOT_MAPPED;
    res_phys   = '0;
    if (cmd_i.fin_dir) begin
      res_status = (op_q == OP_MAP) ? ST_NO_TABLE : ST_NOT_MAPPED;
    end else if (op_q == OP_MAP) begin
      res_status = page_present ? ST_ALREADY : ST_MAPPED;
    end else if (page_present) begin
      res_status = ST_TRANSLATED;
      res_phys   = {page_rdata[ADDR_W-1:OFF_W], vaddr_q[OFF_W-1:0]};
    end
  end

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ADDR_W-1:0]   out_phys_q;
  logic                fin;

  assign fin = cmd_i.fin_dir | cmd_i.fin_page;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_status_q <= res_status;
      out_phys_q   <= res_phys;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_phys_o   = out_phys_q;

  assign sts_o.clear_done  = clear_done;
  assign sts_o.op          = op_q;
  assign sts_o.dir_present = dir_present;
  assign sts_o.pool_full   = pool_full;
  assign sts_o.out_free    = ~out_valid_q | m_tready_i;

endmodule

@@ rtl/core/tlpt_ctrl.sv @@
// controller state machine: clear sweep, directory step, page step
`timescale 1ns / 1ps

`include "two_level_page_table_top_macros.svh"

module tlpt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  tlpt_pkg::dp_status_t sts_i,
  output tlpt_pkg::dp_cmd_t    cmd_o
);

  import tlpt_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_DIR   = 2'd2;
  localparam logic [1:0] S_PAGE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       ready;
  logic       walk_on;

  // the page step is needed when the directory hits or a table can be allocated
  assign walk_on = sts_i.dir_present | ((sts_i.op == OP_MAP) & ~sts_i.pool_full);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ready   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ready = 1'b1;
      end
      S_DIR: begin
        if (walk_on) begin
          cmd_o.page_rd = 1'b1;
          cmd_o.alloc   = ~sts_i.dir_present;
          state_d       = S_PAGE;
        end else if (sts_i.out_free) begin
          cmd_o.fin_dir = 1'b1;
          ready         = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_PAGE: begin
        if (sts_i.out_free) begin
          cmd_o.fin_page = 1'b1;
          ready          = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    // a finishing step takes the next transaction straight away
    if (ready && s_tvalid_i) begin
      cmd_o.load = 1'b1;
      state_d    = S_DIR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = ready;

  `TLPT_ASSERT_NOW(a_no_accept_in_clear, clk_i, rst_ni, state_q == S_CLEAR, !s_tready_o, "accept during clear")
  `TLPT_ASSERT_NOW(a_alloc_legal, clk_i, rst_ni, cmd_o.alloc, (sts_i.op == OP_MAP) && !sts_i.dir_present && !sts_i.pool_full, "illegal table allocation")
  `TLPT_ASSERT_NOW(a_fin_needs_room, clk_i, rst_ni, cmd_o.fin_dir || cmd_o.fin_page, sts_i.out_free, "result while output full")
  `TLPT_ASSERT_NEXT(a_load_to_dir, clk_i, rst_ni, cmd_o.load, state_q == S_DIR, "load did not start a walk")

endmodule

@@ rtl/core/two_level_page_table_top.sv @@
// top level of the two-level page table: controller plus datapath
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser: op, tdata: vaddr, paddr, flags
//  m_axis    out  m_axis_tvalid/tready    tuser: status, tdata: phys_out
//
// after reset the directory and page memories are swept to zero, one entry
// a cycle; no transaction is taken until the sweep is done
// a walk is a directory read, then a page entry read with write back,
// ordered by the two dependent memory reads; the next transaction enters as one finishes
// a translate with no directory entry or a map with no free table ends in the directory step
// a stalled output register holds the walk in its last step until it frees
`timescale 1ns / 1ps

module two_level_page_table_top #(
  parameter int unsigned TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] op
  input  logic                             s_axis_tuser,
  // [31:0] vaddr, [63:32] paddr, [75:64] flags, [79:76] zero
  input  logic [tlpt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status
  output logic [tlpt_pkg::STATUS_W-1:0]    m_axis_tuser,
  // [31:0] phys_out
  output logic [tlpt_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  import tlpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  tlpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tlpt_datapath #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_op_i    (s_axis_tuser),
    .s_tdata_i (s_axis_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tready_i(m_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_status_o(m_axis_tuser),
    .m_phys_o  (m_axis_tdata)
  );

endmodule
